FILE: design/triangle_barycentric_coords_top_defines.svh
// Assertion macros for the triangle barycentric block.
// Used by triangle_barycentric_coords_top; expects clk and rst_n in scope.
`ifndef TRIANGLE_BARYCENTRIC_COORDS_TOP_DEFINES_SVH
`define TRIANGLE_BARYCENTRIC_COORDS_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tbc_pkg.sv
// Shared constants for the triangle barycentric block.
// No dependencies.
package tbc_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int OUT_W           = 25;
  // quotient bits kept below the overflow check; 2^Q_BITS caps the quotient
  localparam int Q_BITS          = 26;
  localparam int LIMIT_W         = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd1;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 25'sh0FFFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 25'sh1000000;
endpackage

FILE: design/triangle_barycentric_coords_top.sv
// Barycentric weights of a point in a 2D triangle: one transaction in per cycle, one out,
// unless stalled. Five setup stages (edge differences, products, determinant and
// numerators, degenerate test, magnitudes), then a restoring divider for all three
// weights side by side whose first stage flags overflow and whose other stages take one
// quotient bit each, then the saturating output register. Each stage moves on when it
// is empty or the next one moves, so a stalled output holds its transaction while earlier
// stages still fill. Depends on tbc_pkg and triangle_barycentric_coords_top_defines.svh.
`include "triangle_barycentric_coords_top_defines.svh"

module triangle_barycentric_coords_top #(
  parameter int COORD_WIDTH      = tbc_pkg::COORD_WIDTH_DEF,
  parameter int WEIGHT_FRAC_BITS = tbc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tbc_pkg::LIMIT_W-1:0]       cfg_degenerate_limit,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     in_v1_x,
  input  logic signed [COORD_WIDTH-1:0]     in_v1_y,
  input  logic signed [COORD_WIDTH-1:0]     in_v2_x,
  input  logic signed [COORD_WIDTH-1:0]     in_v2_y,
  input  logic signed [COORD_WIDTH-1:0]     in_v3_x,
  input  logic signed [COORD_WIDTH-1:0]     in_v3_y,
  input  logic signed [COORD_WIDTH-1:0]     in_point_x,
  input  logic signed [COORD_WIDTH-1:0]     in_point_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tbc_pkg::OUT_W-1:0]  out_weight_one,
  output logic signed [tbc_pkg::OUT_W-1:0]  out_weight_two,
  output logic signed [tbc_pkg::OUT_W-1:0]  out_weight_three,
  output logic                              out_degenerate
);

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = WEIGHT_FRAC_BITS;
  localparam int QB  = tbc_pkg::Q_BITS;
  localparam int OW  = tbc_pkg::OUT_W;
  localparam int LW  = tbc_pkg::LIMIT_W;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int NW  = 2 * CW + 5;
  localparam int MW  = NW;
  localparam int RW  = MW + QB + 1;
  localparam int CMW = (MW > LW) ? MW : LW;
  localparam int NDV = QB + 1;

  typedef struct packed {
    logic [2:0][RW-1:0] rem;
    logic [MW-1:0]      den;
    logic [2:0][QB-1:0] q;
    logic [2:0]         ovf;
    logic [2:0]         neg;
    logic               degen;
  } dv_t;

  // configuration
  logic [LW-1:0] degenerate_limit_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degenerate_limit_r <= tbc_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      degenerate_limit_r <= cfg_degenerate_limit;
    end
  end

  // stage ready chain
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic s1_en, s2_en, s3_en, s4_en, s5_en, out_en;
  logic [NDV-1:0] dv_v_r;
  logic [NDV-1:0] dv_en;

  assign out_en = !out_valid | out_ready;
  assign dv_en[NDV-1] = !dv_v_r[NDV-1] | out_en;
  for (genvar k = 0; k < NDV - 1; k++) begin : g_rdy
    assign dv_en[k] = !dv_v_r[k] | dv_en[k+1];
  end
  assign s5_en = !s5_v_r | dv_en[0];
  assign s4_en = !s4_v_r | s5_en;
  assign s3_en = !s3_v_r | s4_en;
  assign s2_en = !s2_v_r | s3_en;
  assign s1_en = !s1_v_r | s2_en;
  assign in_ready = s1_en;

  // stage 1: edge vectors relative to the third vertex
  logic signed [DW-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (s1_en) begin
      ax_r <= DW'(in_v1_x) - DW'(in_v3_x);
      ay_r <= DW'(in_v1_y) - DW'(in_v3_y);
      bx_r <= DW'(in_v2_x) - DW'(in_v3_x);
      by_r <= DW'(in_v2_y) - DW'(in_v3_y);
      cx_r <= DW'(in_point_x) - DW'(in_v3_x);
      cy_r <= DW'(in_point_y) - DW'(in_v3_y);
    end
  end

  // stage 2: cross products
  logic signed [PW-1:0] p_axby_r, p_bxay_r, p_bycx_r, p_bxcy_r, p_axcy_r, p_aycx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= s1_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (s2_en) begin
      p_axby_r <= ax_r * by_r;
      p_bxay_r <= bx_r * ay_r;
      p_bycx_r <= by_r * cx_r;
      p_bxcy_r <= bx_r * cy_r;
      p_axcy_r <= ax_r * cy_r;
      p_aycx_r <= ay_r * cx_r;
    end
  end

  // stage 3: determinant and first two numerators
  logic signed [NW-1:0] det_r, n1_r, n2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_en) begin
      s3_v_r <= s2_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (s3_en) begin
      det_r <= NW'(p_axby_r) - NW'(p_bxay_r);
      n1_r  <= NW'(p_bycx_r) - NW'(p_bxcy_r);
      n2_r  <= NW'(p_axcy_r) - NW'(p_aycx_r);
    end
  end

  // stage 4: third numerator, degenerate test
  logic signed [NW-1:0] d4_n1_r, d4_n2_r, d4_n3_r;
  logic [MW-1:0]        d4_den_r;
  logic                 d4_dneg_r, d4_degen_r;
  logic [MW-1:0]        det_mag;
  assign det_mag = det_r[NW-1] ? MW'(-det_r) : MW'(det_r);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_en) begin
      s4_v_r <= s3_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (s4_en) begin
      d4_n1_r    <= n1_r;
      d4_n2_r    <= n2_r;
      d4_n3_r    <= det_r - n1_r - n2_r;
      d4_den_r   <= det_mag;
      d4_dneg_r  <= det_r[NW-1];
      d4_degen_r <= (det_mag == '0) || (CMW'(det_mag) < CMW'(degenerate_limit_r));
    end
  end

  // stage 5: numerator magnitudes, scaled into the divider's remainder
  dv_t s5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (s5_en) begin
      s5_v_r <= s4_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (s5_en) begin
      s5_r.rem[0] <= RW'(d4_n1_r[NW-1] ? MW'(-d4_n1_r) : MW'(d4_n1_r)) << FB;
      s5_r.rem[1] <= RW'(d4_n2_r[NW-1] ? MW'(-d4_n2_r) : MW'(d4_n2_r)) << FB;
      s5_r.rem[2] <= RW'(d4_n3_r[NW-1] ? MW'(-d4_n3_r) : MW'(d4_n3_r)) << FB;
      s5_r.neg    <= {d4_n3_r[NW-1] ^ d4_dneg_r, d4_n2_r[NW-1] ^ d4_dneg_r,
                      d4_n1_r[NW-1] ^ d4_dneg_r};
      s5_r.den    <= d4_den_r;
      s5_r.q      <= '0;
      s5_r.ovf    <= '0;
      s5_r.degen  <= d4_degen_r;
    end
  end

  // divider: first stage flags a quotient at or above 2^QB, the rest take one bit each
  dv_t dv_r [NDV];
  for (genvar k = 0; k < NDV; k++) begin : g_dv
    localparam int SH = QB - k;
    dv_t src, dv_nxt;
    logic prev_v;
    if (k == 0) begin : g_src0
      assign src    = s5_r;
      assign prev_v = s5_v_r;
      always_comb begin
        logic [RW-1:0] sub;
        sub = RW'(src.den) << SH;
        dv_nxt = src;
        for (int j = 0; j < 3; j++) begin
          if (src.rem[j] >= sub) begin
            dv_nxt.ovf[j] = 1'b1;
          end
        end
      end
    end else begin : g_srcn
      assign src    = dv_r[k-1];
      assign prev_v = dv_v_r[k-1];
      always_comb begin
        logic [RW-1:0] sub;
        sub = RW'(src.den) << SH;
        dv_nxt = src;
        for (int j = 0; j < 3; j++) begin
          if (src.rem[j] >= sub) begin
            dv_nxt.rem[j] = src.rem[j] - sub;
            dv_nxt.q[j][SH] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (dv_en[k]) begin
        dv_v_r[k] <= prev_v;
      end
    end
    always_ff @(posedge clk) begin
      if (dv_en[k]) begin
        dv_r[k] <= dv_nxt;
      end
    end
  end

  // saturate, sign and register the result
  dv_t dl;
  logic signed [OW-1:0] w_nxt [3];
  assign dl = dv_r[NDV-1];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (dl.degen) begin
        w_nxt[j] = '0;
      end else if (!dl.neg[j]) begin
        if (dl.ovf[j] || (QB'(dl.q[j]) > QB'(tbc_pkg::OUT_MAX))) begin
          w_nxt[j] = tbc_pkg::OUT_MAX;
        end else begin
          w_nxt[j] = OW'(dl.q[j]);
        end
      end else begin
        if (dl.ovf[j] || (dl.q[j] > QB'(1) << (OW - 1))) begin
          w_nxt[j] = tbc_pkg::OUT_MIN;
        end else begin
          w_nxt[j] = -OW'(dl.q[j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= dv_v_r[NDV-1];
    end
  end
  always_ff @(posedge clk) begin
    if (out_en) begin
      out_weight_one   <= w_nxt[0];
      out_weight_two   <= w_nxt[1];
      out_weight_three <= w_nxt[2];
      out_degenerate   <= dl.degen;
    end
  end

  `TBC_ASSERT_NOW(a_degen_zero, out_valid && out_degenerate,
    out_weight_one == '0 && out_weight_two == '0 && out_weight_three == '0,
    "degenerate transaction with nonzero weights")
  `TBC_ASSERT_NOW(a_den_nonzero, dv_v_r[0] && !dv_r[0].degen, dv_r[0].den != '0,
    "zero divisor on a non-degenerate transaction")
  `TBC_ASSERT_NEXT(a_tail_hold, dv_v_r[NDV-1] && out_valid && !out_ready,
    dv_v_r[NDV-1] && out_valid, "divider tail dropped during output stall")
  `TBC_ASSERT_NEXT(a_entry_hold, s1_v_r && !s2_en, s1_v_r,
    "first stage lost a transaction while stalled")

endmodule

FILE: test/testbench.sv
// Self-checking bench for triangle_barycentric_coords_top: directed table, then random traffic.
// Weights are predicted with exact wide integer math; depends on tbc_pkg and the RTL only.
module testbench;

  localparam int CW = tbc_pkg::COORD_WIDTH_DEF;
  localparam int FB = tbc_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 5 + tbc_pkg::Q_BITS + 2;
  localparam int N_RANDOM = 1100;
  localparam int N_DIRECTED = 12;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [tbc_pkg::OUT_W-1:0] wgt_t;

  typedef struct packed {
    coord_t v1x, v1y, v2x, v2y, v3x, v3y, px, py;
  } tri_t;

  typedef struct packed {
    wgt_t w1, w2, w3;
    logic degen;
  } bary_t;

  typedef struct {
    tri_t t;
    logic known;
    bary_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tbc_pkg::LIMIT_W-1:0] cfg_degenerate_limit = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  tri_t in_tri = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  wgt_t out_weight_one, out_weight_two, out_weight_three;
  logic out_degenerate;

  logic [tbc_pkg::LIMIT_W-1:0] degen_limit;
  bary_t pending_weights[$];
  int mismatches = 0;
  bit no_idle = 0;

  always #1 clk = ~clk;

  triangle_barycentric_coords_top DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_degenerate_limit(cfg_degenerate_limit),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_v1_x(in_tri.v1x), .in_v1_y(in_tri.v1y), .in_v2_x(in_tri.v2x), .in_v2_y(in_tri.v2y),
    .in_v3_x(in_tri.v3x), .in_v3_y(in_tri.v3y),
    .in_point_x(in_tri.px), .in_point_y(in_tri.py),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_weight_one(out_weight_one), .out_weight_two(out_weight_two),
    .out_weight_three(out_weight_three), .out_degenerate(out_degenerate)
  );

  // Truncating quotient num*2^FB/den, then clamp to the output range.
  function automatic wgt_t scaled_weight(logic signed [127:0] num, logic signed [127:0] den);
    logic signed [127:0] q;
    q = (num <<< FB) / den;
    if (q > 128'(tbc_pkg::OUT_MAX)) return tbc_pkg::OUT_MAX;
    if (q < -128'sd16777216) return tbc_pkg::OUT_MIN;
    return wgt_t'(q);
  endfunction

  function automatic bary_t predict_weights(tri_t t);
    logic signed [127:0] ax, ay, bx, by, cx, cy, det, n1, n2, n3, mag;
    bary_t r;
    ax = 128'(t.v1x) - 128'(t.v3x);
    ay = 128'(t.v1y) - 128'(t.v3y);
    bx = 128'(t.v2x) - 128'(t.v3x);
    by = 128'(t.v2y) - 128'(t.v3y);
    cx = 128'(t.px) - 128'(t.v3x);
    cy = 128'(t.py) - 128'(t.v3y);
    det = ax * by - bx * ay;
    mag = det < 0 ? -det : det;
    if (det == 0 || mag < 128'(degen_limit)) begin
      r = '0;
      r.degen = 1'b1;
      return r;
    end
    n1 = by * cx - bx * cy;
    n2 = ax * cy - ay * cx;
    n3 = det - n1 - n2;
    r.w1 = scaled_weight(n1, det);
    r.w2 = scaled_weight(n2, det);
    r.w3 = scaled_weight(n3, det);
    r.degen = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // drop valid only when the sender actually goes idle
  task automatic idle_burst();
    int n;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_triangle(tri_t t, logic known, bary_t res);
    bary_t p;
    idle_burst();
    p = known ? res : predict_weights(t);
    in_valid <= 1'b1;
    in_tri <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_weights.push_back(p);
  endtask

  task automatic write_limit(logic [tbc_pkg::LIMIT_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_degenerate_limit <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    degen_limit = v;
  endtask

  function automatic tri_t random_triangle(int mode);
    tri_t t;
    t = {$urandom, $urandom, $urandom, $urandom};
    if (mode == 0) begin
      // small triangle around the point
      t.v1x = t.px + coord_t'($signed($urandom_range(0, 400)) - 200);
      t.v1y = t.py + coord_t'($signed($urandom_range(0, 400)) - 200);
      t.v2x = t.px + coord_t'($signed($urandom_range(0, 400)) - 200);
      t.v2y = t.py + coord_t'($signed($urandom_range(0, 400)) - 200);
      t.v3x = t.px + coord_t'($signed($urandom_range(0, 400)) - 200);
      t.v3y = t.py + coord_t'($signed($urandom_range(0, 400)) - 200);
    end else if (mode == 1) begin
      // collinear vertices
      t.v2x = t.v1x + (t.v1x - t.v3x);
      t.v2y = t.v1y + (t.v1y - t.v3y);
    end
    return t;
  endfunction

  row_t directed[N_DIRECTED];
  localparam bary_t DEGEN = '{w1: '0, w2: '0, w3: '0, degen: 1'b1};
  localparam wgt_t ONE = wgt_t'(1 << FB);
  localparam wgt_t TWO = wgt_t'(2 << FB);

  initial begin
    tri_t t;
    logic [tbc_pkg::LIMIT_W-1:0] lim_set[5];
    degen_limit = tbc_pkg::LIMIT_RESET;
    directed[0] = '{'0, 1'b1, DEGEN};
    // point on a vertex of a unit right triangle
    directed[1] = '{'{16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0},
                    1'b1, '{ONE, '0, '0, 1'b0}};
    directed[2] = '{'{16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
                    1'b1, '{'0, '0, ONE, 1'b0}};
    // far point: first two weights saturate, the third is exactly two
    directed[3] = '{'{16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sh7fff, 16'sh8000},
                    1'b1, '{tbc_pkg::OUT_MAX, tbc_pkg::OUT_MIN, TWO, 1'b0}};
    directed[4] = '{'{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                      16'sh7fff, 16'sh7fff}, 1'b0, '0};
    directed[5] = '{'{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
                      16'sh0000, 16'sh0000}, 1'b0, '0};
    directed[6] = '{'{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd1, 16'sd2},
                    1'b1, DEGEN};
    directed[7] = '{'{16'sd3, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd1, 16'sd1},
                    1'b0, '0};
    directed[8] = '{'{-16'sd2, 16'sd7, 16'sd9, -16'sd4, 16'sd1, 16'sd1, -16'sd3, 16'sd8},
                    1'b0, '0};
    directed[9] = '{'{16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1},
                    1'b0, '0};
    directed[10] = '{'{16'shffff, 16'sh5555, 16'shaaaa, 16'sh0001, 16'sh1234, 16'sh8765,
                       16'shffff, 16'sh0000}, 1'b0, '0};
    directed[11] = '{'{16'sd2, 16'sd0, 16'sd0, 16'sd2, 16'sd0, 16'sd0, 16'sd1, 16'sd1},
                     1'b0, '0};
    lim_set = '{32'd0, 32'hffffffff, 32'd3, 32'd100000, 32'd1};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_triangle(directed[i].t, directed[i].known, directed[i].res);

    for (int phase = 0; phase < 5; phase++) begin
      write_limit(lim_set[phase]);
      if (phase == 0) send_triangle(directed[6].t, 1'b1, DEGEN);  // zero det with limit 0
      if (phase == 4) no_idle = 1;
      for (int k = 0; k < N_RANDOM / 5; k++) begin
        t = random_triangle($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 2));
        send_triangle(t, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: random stall bursts, check each transaction against the oldest prediction.
  initial begin
    bary_t exp_w;
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_weights.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          exp_w = pending_weights.pop_front();
          if (out_weight_one !== exp_w.w1)
            report_mismatch("weight_one", int'(out_weight_one), int'(exp_w.w1));
          if (out_weight_two !== exp_w.w2)
            report_mismatch("weight_two", int'(out_weight_two), int'(exp_w.w2));
          if (out_weight_three !== exp_w.w3)
            report_mismatch("weight_three", int'(out_weight_three), int'(exp_w.w3));
          if (out_degenerate !== exp_w.degen)
            report_mismatch("degenerate", int'(out_degenerate), int'(exp_w.degen));
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

FILE: files.f
+incdir+design
design/tbc_pkg.sv
design/triangle_barycentric_coords_top.sv
test/testbench.sv
